// File: rtl/core/char_lcd_transfer_sequencer_unit_defines.svh
// Assertion macros used by the sequencer RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef CHAR_LCD_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH
`define CHAR_LCD_TRANSFER_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CLTS_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define CLTS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/clts_pkg.sv
package clts_pkg;

	// Request codes.
	localparam logic [2:0] FUNC_CMD   = 3'd0;
	localparam logic [2:0] FUNC_DATA  = 3'd1;
	localparam logic [2:0] FUNC_MOVE  = 3'd2;
	localparam logic [2:0] FUNC_NUM   = 3'd3;
	localparam logic [2:0] FUNC_INIT  = 3'd4;
	localparam logic [2:0] FUNC_GLYPH = 3'd5;

	// Register index of the mode register.
	localparam logic REG_NIB_MODE = 1'b0;

	// Display command and character constants.
	localparam logic [7:0] CMD_FUNCTION_SET = 8'h38;
	localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
	localparam logic [7:0] CMD_CLEAR        = 8'h01;
	localparam logic [7:0] NIB_FUNC_4BIT    = 8'h02;
	localparam logic [7:0] NIB_FUNC_2LINE   = 8'h08;
	localparam logic [7:0] ROW1_BASE        = 8'h80;
	localparam logic [7:0] ROW2_BASE        = 8'hC0;
	localparam logic [1:0] CGRAM_TAG        = 2'b01;
	localparam logic [7:0] CHAR_ZERO        = 8'h30;
	localparam logic [7:0] CHAR_MINUS       = 8'h2D;
	localparam logic [1:0] ROW_FIRST        = 2'd1;
	localparam logic [1:0] ROW_SECOND       = 2'd2;
	localparam logic [2:0] PAT_ROW_LAST     = 3'd7;
	localparam int         PAT_ROW_BITS     = 5;

	// Byte source selected by a control word.
	typedef enum logic [3:0] {
		SRC_VALUE,
		SRC_CONST,
		SRC_GLYPH_CMD,
		SRC_PAT_ROW,
		SRC_CURSOR,
		SRC_SLOT,
		SRC_MINUS,
		SRC_DIGIT,
		SRC_ERR
	} src_t;

	// Branch condition of a control word.
	typedef enum logic [2:0] {
		COND_NEVER,
		COND_ALWAYS,
		COND_EIGHT,
		COND_ROW_BAD,
		COND_ROW_MORE,
		COND_NONNEG
	} cond_t;

	typedef logic [4:0] upc_t;

	// One control word.
	typedef struct packed {
		src_t       src;
		logic [7:0] konst;
		logic       rs;
		logic       emit;
		logic       nib;
		logic       last;
		logic       fin;
		logic       digits;
		logic       inc_row;
		cond_t      cond;
		upc_t       target;
	} uword_t;

	// Request fields held for the length of a request.
	typedef struct packed {
		logic [2:0]  func;
		logic [7:0]  value;
		logic [1:0]  row;
		logic [7:0]  column;
		logic        neg;
		logic [39:0] pattern;
	} req_t;

	// Byte beat from the sequencer to the transfer emitter.
	typedef struct packed {
		logic       rs;
		logic [7:0] data;
		logic       strobe;
		logic       status;
		logic       last;
		logic       nib;
	} beat_t;

	// Digit offered by the decimal unit.
	typedef struct packed {
		logic       valid;
		logic [3:0] digit;
		logic       tail;
	} digit_beat_t;

	// Program addresses.
	localparam upc_t UPC_CMD        = 5'd0;
	localparam upc_t UPC_DATA       = 5'd1;
	localparam upc_t UPC_MOVE       = 5'd2;
	localparam upc_t UPC_MOVE_OK    = 5'd3;
	localparam upc_t UPC_MOVE_ERR   = 5'd4;
	localparam upc_t UPC_NUM        = 5'd5;
	localparam upc_t UPC_MINUS      = 5'd6;
	localparam upc_t UPC_DIGITS     = 5'd7;
	localparam upc_t UPC_INIT       = 5'd8;
	localparam upc_t UPC_INIT4_A    = 5'd9;
	localparam upc_t UPC_INIT4_B    = 5'd10;
	localparam upc_t UPC_INIT4_C    = 5'd11;
	localparam upc_t UPC_INIT8      = 5'd12;
	localparam upc_t UPC_INIT_ON    = 5'd13;
	localparam upc_t UPC_INIT_CLR   = 5'd14;
	localparam upc_t UPC_GLYPH      = 5'd15;
	localparam upc_t UPC_PAT        = 5'd16;
	localparam upc_t UPC_GLYPH_ROW  = 5'd17;
	localparam upc_t UPC_GLYPH_MOVE = 5'd18;
	localparam upc_t UPC_GLYPH_SLOT = 5'd19;

	function automatic uword_t uw(src_t s, logic [7:0] k, logic rs, logic em, logic nib,
		logic last, logic fin, logic dg, logic inc, cond_t c, upc_t t);
		uword_t w;
		w.src     = s;
		w.konst   = k;
		w.rs      = rs;
		w.emit    = em;
		w.nib     = nib;
		w.last    = last;
		w.fin     = fin;
		w.digits  = dg;
		w.inc_row = inc;
		w.cond    = c;
		w.target  = t;
		return w;
	endfunction

	// The control program.
	function automatic uword_t ucode_rom(upc_t pc);
		uword_t w;
		unique case (pc)
			UPC_CMD:        w = uw(SRC_VALUE, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_DATA:       w = uw(SRC_VALUE, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_MOVE:       w = uw(SRC_ERR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				COND_ROW_BAD, UPC_MOVE_ERR);
			UPC_MOVE_OK:    w = uw(SRC_CURSOR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_MOVE_ERR:   w = uw(SRC_ERR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_NUM:        w = uw(SRC_MINUS, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				COND_NONNEG, UPC_DIGITS);
			UPC_MINUS:      w = uw(SRC_MINUS, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_DIGITS:     w = uw(SRC_DIGIT, 8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_INIT:       w = uw(SRC_CONST, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				COND_EIGHT, UPC_INIT8);
			UPC_INIT4_A:    w = uw(SRC_CONST, NIB_FUNC_4BIT, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
				1'b0, COND_NEVER, UPC_CMD);
			UPC_INIT4_B:    w = uw(SRC_CONST, NIB_FUNC_4BIT, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
				1'b0, COND_NEVER, UPC_CMD);
			UPC_INIT4_C:    w = uw(SRC_CONST, NIB_FUNC_2LINE, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
				1'b0, COND_ALWAYS, UPC_INIT_ON);
			UPC_INIT8:      w = uw(SRC_CONST, CMD_FUNCTION_SET, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
				1'b0, 1'b0, COND_NEVER, UPC_CMD);
			UPC_INIT_ON:    w = uw(SRC_CONST, CMD_DISPLAY_ON, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, COND_NEVER, UPC_CMD);
			UPC_INIT_CLR:   w = uw(SRC_CONST, CMD_CLEAR, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
				1'b0, COND_NEVER, UPC_CMD);
			UPC_GLYPH:      w = uw(SRC_GLYPH_CMD, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b0, COND_NEVER, UPC_CMD);
			UPC_PAT:        w = uw(SRC_PAT_ROW, 8'h00, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
				1'b1, COND_ROW_MORE, UPC_PAT);
			UPC_GLYPH_ROW:  w = uw(SRC_ERR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				COND_ROW_BAD, UPC_GLYPH_SLOT);
			UPC_GLYPH_MOVE: w = uw(SRC_CURSOR, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			UPC_GLYPH_SLOT: w = uw(SRC_SLOT, 8'h00, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
			default:        w = uw(SRC_ERR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
				COND_NEVER, UPC_CMD);
		endcase
		return w;
	endfunction

	// Program entry point for each request code.
	function automatic upc_t entry_of(logic [2:0] func);
		upc_t e;
		unique case (func)
			FUNC_CMD:   e = UPC_CMD;
			FUNC_DATA:  e = UPC_DATA;
			FUNC_MOVE:  e = UPC_MOVE;
			FUNC_NUM:   e = UPC_NUM;
			FUNC_INIT:  e = UPC_INIT;
			FUNC_GLYPH: e = UPC_GLYPH;
			default:    e = UPC_CMD;
		endcase
		return e;
	endfunction

	function automatic logic func_known(logic [2:0] func);
		return func <= FUNC_GLYPH;
	endfunction

	// Place values of the decimal digits.
	function automatic logic [31:0] pow10(logic [3:0] pos);
		logic [31:0] p;
		unique case (pos)
			4'd0:    p = 32'd1;
			4'd1:    p = 32'd10;
			4'd2:    p = 32'd100;
			4'd3:    p = 32'd1000;
			4'd4:    p = 32'd10000;
			4'd5:    p = 32'd100000;
			4'd6:    p = 32'd1000000;
			4'd7:    p = 32'd10000000;
			4'd8:    p = 32'd100000000;
			4'd9:    p = 32'd1000000000;
			default: p = 32'd1;
		endcase
		return p;
	endfunction

	localparam logic [3:0] DIGIT_POS_TOP = 4'd9;

endpackage

// File: rtl/core/clts_req_if.sv
interface clts_req_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic [7:0]         value;
	logic [1:0]         row;
	logic [7:0]         column;
	logic signed [31:0] number;
	logic [39:0]        pattern;

	modport source (output valid, func, value, row, column, number, pattern, input ready);
	modport sink (input valid, func, value, row, column, number, pattern, output ready);
endinterface

// File: rtl/core/clts_rsp_if.sv
interface clts_rsp_if;
	logic       valid;
	logic       ready;
	logic       rs;
	logic [7:0] bus_value;
	logic       strobe_res;
	logic       status;
	logic       last;

	modport source (output valid, rs, bus_value, strobe_res, status, last, input ready);
	modport sink (input valid, rs, bus_value, strobe_res, status, last, output ready);
endinterface

// File: rtl/core/char_lcd_transfer_sequencer_unit.sv
// Character-LCD transfer sequencer.
// A request beat on req (command, data, cursor move, signed number, power-up
// sequence or custom glyph) is turned into a run of bus transfers on rsp, one
// beat per transfer, the final one marked by last. The nibble-mode register,
// written over the APB port at address 0, splits each byte into a high and a
// low nibble transfer; power-up nibble commands and error beats go out whole.
// Unknown request codes are taken and produce nothing. req.ready is high only
// while no request is in progress, so one request is worked at a time. A
// command, data byte or glyph emits from its first program step; a cursor move,
// a power-up sequence or a number first takes a step that only branches, and a
// number of zero or more then waits while the decimal unit finds its leading
// digit. Later transfers follow at up to one per cycle while rsp is ready; a
// step that only branches emits no transfer. The decimal unit subtracts the
// current place value while it fits, steps past leading zero places and holds
// each digit until the sequencer takes it. When rsp stalls the output register
// holds its transfer and the program waits at its current step; nothing is lost.
// Reset clears the nibble-mode register and leaves the block idle with no
// transfer pending.
module char_lcd_transfer_sequencer_unit import clts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	clts_req_if.sink    req,
	clts_rsp_if.source  rsp
);

	logic        nib_mode_q;
	logic        cfg_we;
	logic        start;
	logic        seq_busy;
	logic        dec_busy;
	logic [31:0] mag;
	req_t        req_fields;
	digit_beat_t dig;
	logic        dig_take;
	logic        beat_valid;
	logic        beat_ready;
	beat_t       beat;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_NIB_MODE) ? {31'b0, nib_mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nib_mode_q <= 1'b0;
		end else if (cfg_we && paddr[2] == REG_NIB_MODE) begin
			nib_mode_q <= pwdata[0];
		end
	end

	// Request intake.
	assign req.ready = !seq_busy && !dec_busy;
	assign start     = req.valid && req.ready;
	assign mag       = req.number[31] ? (~$unsigned(req.number) + 32'd1)
		: $unsigned(req.number);

	assign req_fields.func    = req.func;
	assign req_fields.value   = req.value;
	assign req_fields.row     = req.row;
	assign req_fields.column  = req.column;
	assign req_fields.neg     = req.number[31];
	assign req_fields.pattern = req.pattern;

	clts_decimal u_decimal (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start && req.func == FUNC_NUM),
		.mag    (mag),
		.take   (dig_take),
		.dig    (dig),
		.busy   (dec_busy)
	);

	clts_sequencer u_sequencer (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req        (req_fields),
		.nib_mode   (nib_mode_q),
		.dig        (dig),
		.dig_take   (dig_take),
		.beat_valid (beat_valid),
		.beat       (beat),
		.beat_ready (beat_ready),
		.busy       (seq_busy)
	);

	clts_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.nib_mode (nib_mode_q),
		.in_valid (beat_valid),
		.in_beat  (beat),
		.in_ready (beat_ready),
		.rsp      (rsp)
	);

endmodule

// File: rtl/core/clts_decimal.sv
module clts_decimal import clts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] mag,
	input  logic        take,
	output digit_beat_t dig,
	output logic        busy
);

	logic [31:0] mag_q;
	logic [3:0]  pos_q;
	logic [3:0]  dig_q;
	logic        started_q;
	logic        busy_q;
	logic        hold_q;
	logic [31:0] place;
	logic        fits;

	// One compare and subtract of the current place value per cycle while no digit is held for the sequencer.
	assign place = pow10(pos_q);
	assign fits  = mag_q >= place;

	assign dig.valid = hold_q;
	assign dig.digit = dig_q;
	assign dig.tail  = (pos_q == 4'd0);
	assign busy      = busy_q;

	// Control of the digit loop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			dig_q     <= '0;
			started_q <= 1'b0;
			busy_q    <= 1'b0;
			hold_q    <= 1'b0;
		end else if (start) begin
			pos_q     <= DIGIT_POS_TOP;
			dig_q     <= '0;
			started_q <= 1'b0;
			busy_q    <= 1'b1;
			hold_q    <= 1'b0;
		end else if (busy_q) begin
			if (hold_q) begin
				if (take) begin
					hold_q    <= 1'b0;
					started_q <= 1'b1;
					dig_q     <= '0;
					if (pos_q == 4'd0) begin
						busy_q <= 1'b0;
					end else begin
						pos_q <= pos_q - 4'd1;
					end
				end
			end else if (fits) begin
				dig_q <= dig_q + 4'd1;
			end else if (dig_q != 4'd0 || started_q || pos_q == 4'd0) begin
				hold_q <= 1'b1;
			end else begin
				pos_q <= pos_q - 4'd1;
			end
		end
	end

	// Remaining magnitude.
	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
		end else if (busy_q && !hold_q && fits) begin
			mag_q <= mag_q - place;
		end
	end

endmodule

// File: rtl/core/clts_emitter.sv
module clts_emitter import clts_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    nib_mode,
	input  logic    in_valid,
	input  beat_t   in_beat,
	output logic    in_ready,
	clts_rsp_if.source rsp
);

	logic  full_q;
	logic  phase_q;
	beat_t beat_q;
	logic  split;
	logic  piece_last;
	logic  out_fire;

	// A strobed byte not marked as a nibble goes out as two nibbles in four-bit mode, high nibble first.
	assign split      = nib_mode && beat_q.strobe && !beat_q.nib;
	assign piece_last = !split || phase_q;
	assign out_fire   = full_q && rsp.ready;
	assign in_ready   = !full_q || (out_fire && piece_last);

	assign rsp.valid      = full_q;
	assign rsp.rs         = beat_q.rs;
	assign rsp.bus_value  = split ? (phase_q ? {4'h0, beat_q.data[3:0]}
		: {4'h0, beat_q.data[7:4]}) : beat_q.data;
	assign rsp.strobe_res = beat_q.strobe;
	assign rsp.status     = beat_q.status;
	assign rsp.last       = beat_q.last && piece_last;

	// Occupancy and nibble phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			full_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (out_fire) begin
			if (piece_last) begin
				full_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	// Held byte beat.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_q <= in_beat;
		end
	end

endmodule

// File: rtl/core/clts_sequencer.sv
`include "char_lcd_transfer_sequencer_unit_defines.svh"

module clts_sequencer import clts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  req_t        req,
	input  logic        nib_mode,
	input  digit_beat_t dig,
	output logic        dig_take,
	output logic        beat_valid,
	output beat_t       beat,
	input  logic        beat_ready,
	output logic        busy
);

	logic       busy_q;
	upc_t       pc_q;
	logic [2:0] row_q;
	req_t       req_q;
	uword_t     w;
	logic [7:0] data;
	logic [2:0] slot;
	logic [7:0] cursor;
	logic       row_bad;
	logic       taken;
	logic       step_done;
	logic       jump;

	assign w       = ucode_rom(pc_q);
	assign slot    = req_q.value[2:0];
	assign row_bad = (req_q.row != ROW_FIRST) && (req_q.row != ROW_SECOND);
	assign cursor  = ((req_q.row == ROW_SECOND) ? ROW2_BASE : ROW1_BASE)
		+ req_q.column - 8'd1;

	// Datapath: byte selected by the control word.
	always_comb begin
		unique case (w.src)
			SRC_VALUE:     data = req_q.value;
			SRC_CONST:     data = w.konst;
			SRC_GLYPH_CMD: data = {CGRAM_TAG, slot, 3'b000};
			SRC_PAT_ROW:   data = {3'b000, req_q.pattern[row_q * PAT_ROW_BITS +: PAT_ROW_BITS]};
			SRC_CURSOR:    data = cursor;
			SRC_SLOT:      data = {5'b00000, slot};
			SRC_MINUS:     data = CHAR_MINUS;
			SRC_DIGIT:     data = CHAR_ZERO + {4'h0, dig.digit};
			SRC_ERR:       data = 8'h00;
			default:       data = 8'h00;
		endcase
	end

	assign beat.rs     = w.rs;
	assign beat.data   = data;
	assign beat.strobe = (w.src != SRC_ERR);
	assign beat.status = (w.src == SRC_ERR);
	assign beat.last   = w.digits ? dig.tail : w.last;
	assign beat.nib    = w.nib;

	assign beat_valid = busy_q && (w.digits ? dig.valid : w.emit);
	assign taken      = beat_valid && beat_ready;
	assign dig_take   = w.digits && taken;
	assign step_done  = busy_q && (taken || !(w.emit || w.digits));
	assign busy       = busy_q;

	// Branch condition.
	always_comb begin
		unique case (w.cond)
			COND_NEVER:    jump = 1'b0;
			COND_ALWAYS:   jump = 1'b1;
			COND_EIGHT:    jump = !nib_mode;
			COND_ROW_BAD:  jump = row_bad;
			COND_ROW_MORE: jump = (row_q != PAT_ROW_LAST);
			COND_NONNEG:   jump = !req_q.neg;
			default:       jump = 1'b0;
		endcase
	end

	// Step counter, row counter and run flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= UPC_CMD;
			row_q  <= '0;
		end else if (start) begin
			busy_q <= func_known(req.func);
			pc_q   <= entry_of(req.func);
			row_q  <= '0;
		end else if (step_done) begin
			if (w.inc_row) begin
				row_q <= row_q + 3'd1;
			end
			if (w.digits) begin
				if (dig.tail) begin
					busy_q <= 1'b0;
				end
			end else if (w.fin) begin
				busy_q <= 1'b0;
			end else if (jump) begin
				pc_q <= w.target;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	// Request fields for the running program.
	always_ff @(posedge clk) begin
		if (start) begin
			req_q <= req;
		end
	end

	`CLTS_ASSERT_IMP(ap_take_needs_digit, dig_take, dig.valid,
		"digit taken while none offered")
	`CLTS_ASSERT_IMP(ap_idle_quiet, !busy_q, !beat_valid,
		"byte beat offered while idle")
	`CLTS_ASSERT_IMP(ap_end_on_last, $fell(busy_q), $past(taken && beat.last),
		"program ended without a final beat")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import clts_pkg::*;

	// Register select values and status flags of one transfer.
	localparam logic RS_CMD         = 1'b0;
	localparam logic RS_DATA        = 1'b1;
	localparam logic STROBE_PULSE   = 1'b1;
	localparam logic STROBE_NONE    = 1'b0;
	localparam logic STATUS_OK      = 1'b0;
	localparam logic STATUS_BAD_ROW = 1'b1;

	// Request codes the block takes but ignores, and rows outside the display.
	localparam logic [2:0] FUNC_UNUSED_LO = 3'd6;
	localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
	localparam logic [1:0] ROW_NONE       = 2'd0;
	localparam logic [1:0] ROW_BEYOND     = 2'd3;

	localparam logic signed [31:0] NUM_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] NUM_MAX = 32'sh7fff_ffff;

	// The mode register sits at byte address four times its index.
	localparam logic [2:0] MODE_ADDR = {REG_NIB_MODE, 2'b00};

	localparam int SETTLE_CYCLES     = 16;
	localparam int END_CYCLES        = 150;
	localparam int LONG_STALL_CYCLES = 400;
	localparam int MAX_PRINTS        = 40;

	typedef struct {
		logic [2:0]         func;
		logic [7:0]         value;
		logic [1:0]         row;
		logic [7:0]         column;
		logic signed [31:0] number;
		logic [39:0]        pattern;
	} lcd_req_t;

	typedef struct {
		logic       rs;
		logic [7:0] bus_value;
		logic       strobe;
		logic       status;
		logic       last;
	} lcd_transfer_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	clts_req_if req_if();
	clts_rsp_if rsp_if();

	char_lcd_transfer_sequencer_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	// Predicted display state and the transfers still owed by the block.
	logic          model_nib_mode = 1'b0;
	lcd_transfer_t request_run[$];
	lcd_transfer_t expected_transfers[$];
	int            mismatch_count = 0;
	int            source_idle_pct = 0;
	int            sink_idle_pct = 0;
	logic          receiver_held = 1'b0;
	event          long_stall_go;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		if (mismatch_count < MAX_PRINTS) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
		mismatch_count++;
	endtask

	// Transfer prediction.
	function automatic void put_transfer(logic rs, logic [7:0] bus, logic strobe,
		logic status);
		lcd_transfer_t t;
		t.rs        = rs;
		t.bus_value = bus;
		t.strobe    = strobe;
		t.status    = status;
		t.last      = 1'b0;
		request_run.push_back(t);
	endfunction

	// In nibble mode a byte goes out as its high nibble, then its low nibble.
	function automatic void put_byte(logic rs, logic [7:0] b);
		if (model_nib_mode) begin
			put_transfer(rs, {4'h0, b[7:4]}, STROBE_PULSE, STATUS_OK);
			put_transfer(rs, {4'h0, b[3:0]}, STROBE_PULSE, STATUS_OK);
		end else begin
			put_transfer(rs, b, STROBE_PULSE, STATUS_OK);
		end
	endfunction

	// Returns 0 when the row is not on the display; nothing is sent then.
	function automatic logic put_cursor(logic [1:0] row, logic [7:0] column);
		logic [7:0] pos;
		if (row == ROW_FIRST) begin
			pos = ROW1_BASE + column - 8'd1;
			put_byte(RS_CMD, pos);
			return 1'b1;
		end
		if (row == ROW_SECOND) begin
			pos = ROW2_BASE + column - 8'd1;
			put_byte(RS_CMD, pos);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Sign first, then the decimal digits from the most significant one.
	function automatic void put_decimal(logic signed [31:0] number);
		logic [31:0] mag;
		logic [7:0]  digs [10];
		int          n;
		if (number < 0) begin
			put_byte(RS_DATA, CHAR_MINUS);
			mag = ~number + 32'd1;
		end else begin
			mag = number;
		end
		n = 0;
		do begin
			digs[n] = 8'(mag % 32'd10);
			mag = mag / 32'd10;
			n++;
		end while (mag != 0);
		while (n > 0) begin
			n--;
			put_byte(RS_DATA, CHAR_ZERO + digs[n]);
		end
	endfunction

	function automatic void predict_transfers(lcd_req_t r);
		logic [2:0] slot;
		request_run.delete();
		case (r.func)
			FUNC_CMD: begin
				put_byte(RS_CMD, r.value);
			end
			FUNC_DATA: begin
				put_byte(RS_DATA, r.value);
			end
			FUNC_MOVE: begin
				if (!put_cursor(r.row, r.column)) begin
					put_transfer(RS_CMD, 8'h00, STROBE_NONE, STATUS_BAD_ROW);
				end
			end
			FUNC_NUM: begin
				put_decimal(r.number);
			end
			FUNC_INIT: begin
				if (model_nib_mode) begin
					put_transfer(RS_CMD, NIB_FUNC_4BIT, STROBE_PULSE, STATUS_OK);
					put_transfer(RS_CMD, NIB_FUNC_4BIT, STROBE_PULSE, STATUS_OK);
					put_transfer(RS_CMD, NIB_FUNC_2LINE, STROBE_PULSE, STATUS_OK);
				end else begin
					put_byte(RS_CMD, CMD_FUNCTION_SET);
				end
				put_byte(RS_CMD, CMD_DISPLAY_ON);
				put_byte(RS_CMD, CMD_CLEAR);
			end
			FUNC_GLYPH: begin
				// Only the low three bits of value pick the glyph slot.
				slot = r.value[2:0];
				put_byte(RS_CMD, {CGRAM_TAG, slot, 3'b000});
				for (int k = 0; k < 8; k++) begin
					put_byte(RS_DATA, {3'b000, r.pattern[PAT_ROW_BITS*k +: PAT_ROW_BITS]});
				end
				// A bad row just drops the cursor move; no error is flagged.
				void'(put_cursor(r.row, r.column));
				put_byte(RS_DATA, {5'b00000, slot});
			end
			default: begin
			end
		endcase
		if (request_run.size() > 0) begin
			request_run[request_run.size() - 1].last = 1'b1;
		end
		foreach (request_run[i]) begin
			expected_transfers.push_back(request_run[i]);
		end
	endfunction

	// Result checking: every accepted beat against the oldest prediction.
	always @(posedge clk) begin
		lcd_transfer_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (expected_transfers.size() == 0) begin
				report_mismatch($sformatf("unexpected beat rs=%0b bus=%02h strobe=%0b last=%0b",
					rsp_if.rs, rsp_if.bus_value, rsp_if.strobe_res, rsp_if.last));
			end else begin
				want = expected_transfers.pop_front();
				if (rsp_if.rs !== want.rs) begin
					report_mismatch($sformatf("rs got %0b want %0b", rsp_if.rs, want.rs));
				end
				if (rsp_if.bus_value !== want.bus_value) begin
					report_mismatch($sformatf("bus_value got %02h want %02h",
						rsp_if.bus_value, want.bus_value));
				end
				if (rsp_if.strobe_res !== want.strobe) begin
					report_mismatch($sformatf("strobe_res got %0b want %0b",
						rsp_if.strobe_res, want.strobe));
				end
				if (rsp_if.status !== want.status) begin
					report_mismatch($sformatf("status got %0b want %0b",
						rsp_if.status, want.status));
				end
				if (rsp_if.last !== want.last) begin
					report_mismatch($sformatf("last got %0b want %0b", rsp_if.last, want.last));
				end
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold when asked for.
	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp_if.ready <= !receiver_held && ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Long receiver hold, counted here in clock cycles.
	initial begin
		forever begin
			@(long_stall_go);
			receiver_held <= 1'b1;
			repeat (LONG_STALL_CYCLES) @(posedge clk);
			receiver_held <= 1'b0;
		end
	end

	// Offers one request beat and records its transfers once it is taken.
	task automatic send_request(input lcd_req_t r);
		while ($urandom_range(99) < source_idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.func    <= r.func;
		req_if.value   <= r.value;
		req_if.row     <= r.row;
		req_if.column  <= r.column;
		req_if.number  <= r.number;
		req_if.pattern <= r.pattern;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		predict_transfers(r);
	endtask

	function automatic lcd_req_t make_request(logic [2:0] func, logic [7:0] value,
		logic [1:0] row, logic [7:0] column, logic signed [31:0] number, logic [39:0] pattern);
		lcd_req_t r;
		r.func    = func;
		r.value   = value;
		r.row     = row;
		r.column  = column;
		r.number  = number;
		r.pattern = pattern;
		return r;
	endfunction

	function automatic lcd_req_t random_request();
		lcd_req_t           r;
		int                 pick;
		logic signed [31:0] num;
		pick = $urandom_range(99);
		if (pick < 14) r.func = FUNC_CMD;
		else if (pick < 28) r.func = FUNC_DATA;
		else if (pick < 44) r.func = FUNC_MOVE;
		else if (pick < 64) r.func = FUNC_NUM;
		else if (pick < 72) r.func = FUNC_INIT;
		else if (pick < 94) r.func = FUNC_GLYPH;
		else r.func = $urandom_range(1) ? FUNC_UNUSED_HI : FUNC_UNUSED_LO;
		r.value  = 8'($urandom);
		r.column = 8'($urandom);
		if ($urandom_range(9) < 8) begin
			r.row = $urandom_range(1) ? ROW_FIRST : ROW_SECOND;
		end else begin
			r.row = $urandom_range(1) ? ROW_NONE : ROW_BEYOND;
		end
		// Numbers: full range, small values, digit-count boundaries, extremes.
		case ($urandom_range(3))
			0: num = $urandom;
			1: num = $signed($urandom_range(2000)) - 1000;
			2: begin
				num = 1;
				repeat ($urandom_range(9)) num = num * 10;
				num = num - $urandom_range(1);
				if ($urandom_range(1)) num = -num;
			end
			default: num = $urandom_range(1) ? NUM_MIN : NUM_MAX;
		endcase
		r.number  = num;
		r.pattern = {8'($urandom), 32'($urandom)};
		return r;
	endfunction

	// Config port access, one setup and one access phase.
	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		data = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Lets every owed transfer come out and the block fall idle.
	task automatic drain_block();
		req_if.valid <= 1'b0;
		while (expected_transfers.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic nib_mode);
		drain_block();
		apb_write(MODE_ADDR, {31'd0, nib_mode});
		model_nib_mode = nib_mode;
	endtask

	task automatic set_idling(input int source_pct, input int sink_pct);
		source_idle_pct = source_pct;
		sink_idle_pct   = sink_pct;
	endtask

	task automatic test_register_access();
		logic [31:0] rd;
		set_mode(1'b1);
		apb_read(MODE_ADDR, rd);
		if (rd[0] !== 1'b1) report_mismatch("nibble mode did not read back as 1");
		set_mode(1'b0);
		apb_read(MODE_ADDR, rd);
		if (rd[0] !== 1'b0) report_mismatch("nibble mode did not read back as 0");
	endtask

	// Byte mode: field extremes, every request type, bad rows, number extremes.
	task automatic test_directed_byte_mode();
		set_mode(1'b0);
		send_request(make_request(FUNC_CMD, 8'h00, ROW_FIRST, 8'd1, 0, 40'd0));
		send_request(make_request(FUNC_DATA, 8'hFF, ROW_SECOND, 8'd255, -1, '1));
		send_request(make_request(FUNC_MOVE, 8'h00, ROW_FIRST, 8'd1, 0, 40'd0));
		// Column zero wraps the position byte below the row base.
		send_request(make_request(FUNC_MOVE, 8'h00, ROW_SECOND, 8'd0, 0, 40'd0));
		send_request(make_request(FUNC_MOVE, 8'hFF, ROW_FIRST, 8'd255, 0, 40'd0));
		send_request(make_request(FUNC_MOVE, 8'h00, ROW_NONE, 8'd5, 0, 40'd0));
		send_request(make_request(FUNC_MOVE, 8'h00, ROW_BEYOND, 8'd5, 0, 40'd0));
		send_request(make_request(FUNC_NUM, 8'h00, ROW_FIRST, 8'd1, 0, 40'd0));
		send_request(make_request(FUNC_NUM, 8'h00, ROW_FIRST, 8'd1, -1, 40'd0));
		send_request(make_request(FUNC_NUM, 8'h00, ROW_FIRST, 8'd1, NUM_MAX, 40'd0));
		send_request(make_request(FUNC_NUM, 8'h00, ROW_FIRST, 8'd1, NUM_MIN, 40'd0));
		send_request(make_request(FUNC_INIT, 8'h00, ROW_FIRST, 8'd1, 0, 40'd0));
		send_request(make_request(FUNC_GLYPH, 8'h00, ROW_FIRST, 8'd1, 0, 40'd0));
		// Slot out of range and a bad row: low slot bits only, no cursor move.
		send_request(make_request(FUNC_GLYPH, 8'hFF, ROW_BEYOND, 8'd200, 0, '1));
		send_request(make_request(FUNC_UNUSED_LO, 8'h12, ROW_FIRST, 8'd3, 7, 40'd9));
		send_request(make_request(FUNC_UNUSED_HI, 8'h34, ROW_SECOND, 8'd4, 8, 40'd10));
	endtask

	// Nibble mode: the same request types split into high and low halves.
	task automatic test_directed_nibble_mode();
		set_mode(1'b1);
		send_request(make_request(FUNC_CMD, 8'hA5, ROW_FIRST, 8'd1, 0, 40'd0));
		send_request(make_request(FUNC_DATA, 8'h3C, ROW_FIRST, 8'd1, 0, 40'd0));
		send_request(make_request(FUNC_MOVE, 8'h00, ROW_SECOND, 8'd40, 0, 40'd0));
		send_request(make_request(FUNC_MOVE, 8'h00, ROW_NONE, 8'd40, 0, 40'd0));
		send_request(make_request(FUNC_NUM, 8'h00, ROW_FIRST, 8'd1, NUM_MIN, 40'd0));
		send_request(make_request(FUNC_INIT, 8'h00, ROW_FIRST, 8'd1, 0, 40'd0));
		send_request(make_request(FUNC_GLYPH, 8'h0B, ROW_SECOND, 8'd5, 0,
			40'h5A_C3_96_3C_A5));
		send_request(make_request(FUNC_GLYPH, 8'h06, ROW_NONE, 8'd9, 0,
			40'h12_34_56_78_9A));
		send_request(make_request(FUNC_NUM, 8'h00, ROW_FIRST, 8'd1, 1234567890, 40'd0));
	endtask

	// Random requests; ignored request codes do not count toward the total.
	task automatic test_random_requests(input logic nib_mode, input int count);
		lcd_req_t r;
		int       taken;
		set_mode(nib_mode);
		taken = 0;
		while (taken < count) begin
			r = random_request();
			send_request(r);
			if (r.func <= FUNC_GLYPH) taken++;
		end
	endtask

	// The receiver holds off while requests keep coming, so the input stalls.
	task automatic test_receiver_long_stall();
		set_mode(1'b0);
		-> long_stall_go;
		repeat (12) send_request(random_request());
	endtask

	// The sender stops until every owed transfer is out, then resumes.
	task automatic test_sender_pause();
		set_mode(1'b0);
		repeat (6) send_request(random_request());
		req_if.valid <= 1'b0;
		while (expected_transfers.size() != 0) @(posedge clk);
		repeat (6) send_request(random_request());
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_if.valid   = 1'b0;
		req_if.func    = FUNC_CMD;
		req_if.value   = '0;
		req_if.row     = '0;
		req_if.column  = '0;
		req_if.number  = '0;
		req_if.pattern = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(26, 51);
		test_register_access();
		test_directed_byte_mode();
		test_directed_nibble_mode();
		test_random_requests(1'b0, 35);
		set_idling(51, 26);
		test_random_requests(1'b1, 35);
		test_receiver_long_stall();
		set_idling(0, 0);
		test_random_requests(1'b1, 30);
		test_sender_pause();

		req_if.valid <= 1'b0;
		while (expected_transfers.size() != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS char_lcd_transfer_sequencer_unit");
		end else begin
			$display("FAIL char_lcd_transfer_sequencer_unit");
		end
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#2_000_000;
		$display("FAIL char_lcd_transfer_sequencer_unit");
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/clts_pkg.sv
rtl/core/clts_req_if.sv
rtl/core/clts_rsp_if.sv
rtl/core/clts_decimal.sv
rtl/core/clts_emitter.sv
rtl/core/clts_sequencer.sv
rtl/core/char_lcd_transfer_sequencer_unit.sv
tb/tb_top.sv
